[rtl/pacq_pkg.sv]
// Shared types, action codes, status codes and the action decode table
// for the pending action queue coalescer. No dependencies.
`default_nettype none

package pacq_pkg;

    typedef logic [3:0] act_t;
    typedef logic [2:0] status_t;

    // Action codes
    localparam act_t ACT_CREATE_RT  = 4'd0;
    localparam act_t ACT_DESTROY_RT = 4'd1;
    localparam act_t ACT_CREATE_RB  = 4'd2;
    localparam act_t ACT_DESTROY_RB = 4'd3;
    localparam act_t ACT_UPDATE_RB  = 4'd4;
    localparam act_t ACT_CREATE_BP  = 4'd5;
    localparam act_t ACT_DESTROY_BP = 4'd6;
    localparam act_t ACT_CREATE_DB  = 4'd7;
    localparam act_t ACT_DESTROY_DB = 4'd8;
    localparam act_t ACT_UPDATE_DB  = 4'd9;
    localparam act_t ACT_CREATE_TB  = 4'd10;
    localparam act_t ACT_UPDATE_TB  = 4'd11;
    localparam act_t ACT_DESTROY_TB = 4'd12;
    localparam act_t ACT_CREATE_UB  = 4'd13;
    localparam act_t ACT_DESTROY_UB = 4'd14;
    localparam act_t ACT_UPDATE_UB  = 4'd15;

    // Result status codes
    localparam status_t ST_APPENDED  = 3'd0;
    localparam status_t ST_CANCELLED = 3'd1;
    localparam status_t ST_DUP       = 3'd2;
    localparam status_t ST_FULL      = 3'd3;
    localparam status_t ST_POPPED    = 3'd4;
    localparam status_t ST_EMPTY     = 3'd5;

    // Opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // What a pushed action does to the queue
    typedef struct packed {
        logic purge_en;     // remove all queued purge_code entries for the handle
        act_t purge_code;
        logic cancel_en;    // remove the first queued cancel_code entry
        act_t cancel_code;
        logic is_upd;       // drop if already queued
    } code_ctl_t;

    // Compare results for one queued entry
    typedef struct packed {
        logic purge;
        logic cancel;
        logic dup;
    } match_t;

    function automatic code_ctl_t decode_action(act_t a);
        code_ctl_t c;
        c = '0;
        unique case (a)
            ACT_DESTROY_RT: begin
                c.cancel_en = 1'b1; c.cancel_code = ACT_CREATE_RT;
            end
            ACT_DESTROY_RB: begin
                c.purge_en  = 1'b1; c.purge_code  = ACT_UPDATE_RB;
                c.cancel_en = 1'b1; c.cancel_code = ACT_CREATE_RB;
            end
            ACT_DESTROY_BP: begin
                c.cancel_en = 1'b1; c.cancel_code = ACT_CREATE_BP;
            end
            ACT_DESTROY_DB: begin
                c.purge_en  = 1'b1; c.purge_code  = ACT_UPDATE_DB;
                c.cancel_en = 1'b1; c.cancel_code = ACT_CREATE_DB;
            end
            ACT_DESTROY_TB: begin
                c.purge_en  = 1'b1; c.purge_code  = ACT_UPDATE_TB;
                c.cancel_en = 1'b1; c.cancel_code = ACT_CREATE_TB;
            end
            ACT_DESTROY_UB: begin
                c.purge_en  = 1'b1; c.purge_code  = ACT_UPDATE_UB;
                c.cancel_en = 1'b1; c.cancel_code = ACT_CREATE_UB;
            end
            ACT_UPDATE_RB, ACT_UPDATE_DB, ACT_UPDATE_TB, ACT_UPDATE_UB: begin
                c.is_upd = 1'b1;
            end
            default: begin
                c = '0;     // creates pass straight through
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/pacq_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module pacq_ram #(
    parameter int unsigned WIDTH = 36,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/pacq_match.sv]
// Shared compare unit: checks one queued entry against the pushed key.
// Depends on pacq_pkg.
`default_nettype none

module pacq_match #(
    parameter int unsigned HANDLE_BITS = 32
) (
    input  wire logic [HANDLE_BITS-1:0] key_handle,
    input  wire pacq_pkg::act_t         key_action,
    input  wire pacq_pkg::code_ctl_t    ctl,
    input  wire logic [HANDLE_BITS-1:0] entry_handle,
    input  wire pacq_pkg::act_t         entry_action,
    output pacq_pkg::match_t            hit
);
    import pacq_pkg::*;

    logic same_handle;

    assign same_handle = (entry_handle == key_handle);

    always_comb begin
        hit.purge  = same_handle && ctl.purge_en  && (entry_action == ctl.purge_code);
        hit.cancel = same_handle && ctl.cancel_en && (entry_action == ctl.cancel_code);
        hit.dup    = same_handle && ctl.is_upd    && (entry_action == key_action);
    end

endmodule

`default_nettype wire

[rtl/pending_action_queue_coalescer.sv]
// Top level of the pending action queue coalescer: sequencer, queue
// pointers and output register. Depends on pacq_pkg, pacq_ram, pacq_match.
`default_nettype none

// Ordered queue of pending resource actions (handle + 4-bit action code) held
// as a circular buffer in one RAM, with a shared compare unit walked over the
// queue by a small sequencer. One transaction in, one result transaction out.
// A pop (s_tuser = 1) returns the head entry, or status EMPTY; a create push
// appends without a walk. A destroy push walks the whole queue once,
// one entry per cycle through the RAM read port, dropping matching updates
// and the first matching create and compacting the rest in place; an update
// push walks the queue looking for a duplicate. s_tready is high only while
// the sequencer is idle. The result sits in an output register, so the next
// transaction can be taken while it waits; the sequencer only stalls when it
// has a new result and the old one is unread. Entries are never read beyond
// the fill count, so the RAM needs no clearing.
module pending_action_queue_coalescer #(
    parameter int unsigned QUEUE_DEPTH = 32,
    parameter int unsigned HANDLE_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] res_handle, [35:32] action_code
    input  wire logic        s_tuser,   // [0] opcode
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // [31:0] out_handle, [35:32] out_action,
                                        // [41:36] updates_removed, [47:42] queue_count
    output logic      [2:0]  m_tuser    // [2:0] status
);
    import pacq_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned EW = HANDLE_BITS + 4;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_POP_RD = 3'd1;
    localparam logic [2:0] S_POP    = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    // control state
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          m_valid_reg, m_valid_next;

    // per-transaction working registers
    logic [HANDLE_BITS-1:0] key_h_reg, key_h_next;
    act_t                   key_a_reg, key_a_next;
    code_ctl_t              ctl_reg, ctl_next;
    logic [AW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]          rd_idx_reg, rd_idx_next;
    logic [CW-1:0]          wr_cnt_reg, wr_cnt_next;
    logic [CW-1:0]          removed_reg, removed_next;
    logic                   pend_reg, pend_next;
    logic                   cancel_reg, cancel_next;
    logic                   dup_reg, dup_next;

    // result register
    status_t                res_status_reg, res_status_next;
    logic [31:0]            res_handle_reg, res_handle_next;
    act_t                   res_action_reg, res_action_next;
    logic [5:0]             res_removed_reg, res_removed_next;
    logic [5:0]             res_count_reg, res_count_next;

    // RAM port
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic [HANDLE_BITS-1:0] ent_h;
    act_t                   ent_a;
    match_t                 hit;

    logic                   in_fire, out_free, compact;
    logic [HANDLE_BITS+31:0] in_h_ext;
    logic [HANDLE_BITS+31:0] out_h_ext;
    logic [CW+5:0]          cnt_ext, rem_ext;
    logic [CW-1:0]          fin_cnt;
    logic [AW-1:0]          fin_tail;

    assign ent_h = ram_rdata[HANDLE_BITS-1:0];
    assign ent_a = ram_rdata[EW-1:HANDLE_BITS];

    pacq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pacq_match #(
        .HANDLE_BITS (HANDLE_BITS)
    ) u_match (
        .key_handle   (key_h_reg),
        .key_action   (key_a_reg),
        .ctl          (ctl_reg),
        .entry_handle (ent_h),
        .entry_action (ent_a),
        .hit          (hit)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign compact  = ctl_reg.purge_en || ctl_reg.cancel_en;

    // handle is kept in its low HANDLE_BITS bits
    assign in_h_ext  = {32'd0, HANDLE_BITS'(0)} | (HANDLE_BITS + 32)'(s_tdata[31:0]);
    assign out_h_ext = {32'd0, ent_h};

    // after a compacting walk the write pointer is the new tail
    assign fin_cnt  = compact ? wr_cnt_reg : count_reg;
    assign fin_tail = compact ? wr_ptr_reg : tail_reg;

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        key_h_next       = key_h_reg;
        key_a_next       = key_a_reg;
        ctl_next         = ctl_reg;
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        rd_idx_next      = rd_idx_reg;
        wr_cnt_next      = wr_cnt_reg;
        removed_next     = removed_reg;
        pend_next        = 1'b0;
        cancel_next      = cancel_reg;
        dup_next         = dup_reg;
        res_status_next  = res_status_reg;
        res_handle_next  = res_handle_reg;
        res_action_next  = res_action_reg;
        res_removed_next = res_removed_reg;
        res_count_next   = res_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = wr_ptr_reg;
        ram_wdata        = ram_rdata;
        ram_re           = 1'b0;
        ram_raddr        = rd_ptr_reg;
        cnt_ext          = '0;
        rem_ext          = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    key_h_next   = in_h_ext[HANDLE_BITS-1:0];
                    key_a_next   = s_tdata[35:32];
                    ctl_next     = decode_action(s_tdata[35:32]);
                    rd_ptr_next  = head_reg;
                    wr_ptr_next  = head_reg;
                    rd_idx_next  = '0;
                    wr_cnt_next  = '0;
                    removed_next = '0;
                    cancel_next  = 1'b0;
                    dup_next     = 1'b0;
                    if (s_tuser == OP_POP) begin
                        state_next = S_POP_RD;
                    end else if (ctl_next.purge_en || ctl_next.cancel_en
                                 || ctl_next.is_upd) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_POP_RD: begin
                ram_raddr  = head_reg;
                ram_re     = (count_reg != '0);
                state_next = S_POP;
            end

            S_POP: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    res_removed_next = '0;
                    if (count_reg == '0) begin
                        res_status_next = ST_EMPTY;
                        res_handle_next = '0;
                        res_action_next = '0;
                    end else begin
                        res_status_next = ST_POPPED;
                        res_handle_next = out_h_ext[31:0];
                        res_action_next = ent_a;
                        head_next       = ptr_inc(head_reg);
                        count_next      = count_reg - 1'b1;
                    end
                    cnt_ext        = {6'd0, count_next};
                    res_count_next = cnt_ext[5:0];
                    state_next     = S_IDLE;
                end
            end

            S_SCAN: begin
                // entry read last cycle goes through the compare unit
                if (pend_reg) begin
                    if (compact) begin
                        if (hit.purge) begin
                            removed_next = removed_reg + 1'b1;
                        end else if (hit.cancel && !cancel_reg) begin
                            cancel_next = 1'b1;
                        end else begin
                            ram_we      = 1'b1;
                            ram_waddr   = wr_ptr_reg;
                            ram_wdata   = ram_rdata;
                            wr_ptr_next = ptr_inc(wr_ptr_reg);
                            wr_cnt_next = wr_cnt_reg + 1'b1;
                        end
                    end else if (hit.dup) begin
                        dup_next = 1'b1;
                    end
                end
                // issue the next read; write slot never passes the read slot.
                // The last compare lands in the working registers at this edge.
                if (rd_idx_reg != count_reg) begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_ptr_reg;
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                    rd_idx_next = rd_idx_reg + 1'b1;
                    pend_next   = 1'b1;
                end else begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    res_handle_next  = '0;
                    res_action_next  = '0;
                    rem_ext          = {6'd0, removed_reg};
                    res_removed_next = rem_ext[5:0];
                    count_next       = fin_cnt;
                    tail_next        = fin_tail;
                    if (cancel_reg) begin
                        res_status_next = ST_CANCELLED;
                    end else if (dup_reg) begin
                        res_status_next = ST_DUP;
                    end else if (fin_cnt == CW'(QUEUE_DEPTH)) begin
                        res_status_next = ST_FULL;
                    end else begin
                        res_status_next = ST_APPENDED;
                        ram_we          = 1'b1;
                        ram_waddr       = fin_tail;
                        ram_wdata       = {key_a_reg, key_h_reg};
                        tail_next       = ptr_inc(fin_tail);
                        count_next      = fin_cnt + 1'b1;
                    end
                    cnt_ext        = {6'd0, count_next};
                    res_count_next = cnt_ext[5:0];
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_h_reg       <= key_h_next;
        key_a_reg       <= key_a_next;
        ctl_reg         <= ctl_next;
        rd_ptr_reg      <= rd_ptr_next;
        wr_ptr_reg      <= wr_ptr_next;
        rd_idx_reg      <= rd_idx_next;
        wr_cnt_reg      <= wr_cnt_next;
        removed_reg     <= removed_next;
        cancel_reg      <= cancel_next;
        dup_reg         <= dup_next;
        res_status_reg  <= res_status_next;
        res_handle_reg  <= res_handle_next;
        res_action_reg  <= res_action_next;
        res_removed_reg <= res_removed_next;
        res_count_reg   <= res_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_status_reg;
    assign m_tdata  = {res_count_reg, res_removed_reg, res_action_reg, res_handle_reg};

endmodule

`default_nettype wire

[sim/pending_action_queue_coalescer_tb.sv]
// Testbench for pending_action_queue_coalescer: directed and random push/pop
// transactions checked against a queue model kept in a small scoreboard class.
// Depends on pacq_pkg and the RTL top level only.
`timescale 1ns / 100ps

module pending_action_queue_coalescer_tb;
    import pacq_pkg::*;

    localparam int unsigned QUEUE_DEPTH   = 32;
    localparam real         CLK_PERIOD    = 8.0;
    localparam int unsigned RESET_CYCLES  = 6;
    localparam int unsigned PHASES        = 15;
    localparam int unsigned PHASE_ITEMS   = 50;     // 15 x 50 = 750 random transactions
    localparam int unsigned LONG_HOLD     = 600;    // receiver hold-off, in cycles
    localparam int unsigned DRAIN_CYCLES  = 40;     // idle time after the last result
    localparam int unsigned WATCHDOG      = 5000;   // cycles with no transaction at all
    localparam int unsigned POOL_SIZE     = 4;

    // Resource kinds in order: render target, render buffer, blit pass,
    // data buffer, texture buffer, uniform buffer. Render targets and blit
    // passes have no update; their update slot repeats the create.
    localparam act_t CREATE_OF  [6] = '{ACT_CREATE_RT, ACT_CREATE_RB, ACT_CREATE_BP,
                                        ACT_CREATE_DB, ACT_CREATE_TB, ACT_CREATE_UB};
    localparam act_t UPDATE_OF  [6] = '{ACT_CREATE_RT, ACT_UPDATE_RB, ACT_CREATE_BP,
                                        ACT_UPDATE_DB, ACT_UPDATE_TB, ACT_UPDATE_UB};
    localparam act_t DESTROY_OF [6] = '{ACT_DESTROY_RT, ACT_DESTROY_RB, ACT_DESTROY_BP,
                                        ACT_DESTROY_DB, ACT_DESTROY_TB, ACT_DESTROY_UB};

    typedef struct packed {
        logic [31:0] handle;
        act_t        action;
    } queue_entry_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] handle;
        act_t        action;
        logic [5:0]  removed;
        logic [5:0]  count;
    } queue_result_t;

    // Scoreboard: a copy of the queue contents plus the results still owed
    // by the block, oldest first.
    class action_queue_board;
        queue_entry_t  held[$];
        queue_result_t awaited[$];
        int unsigned   errors;

        function new();
            errors = 0;
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        // Which queued entries a pushed action purges, cancels or dedupes against
        function void action_rules(input act_t a, output bit purge, output act_t purge_code,
                                   output bit cancel, output act_t cancel_code,
                                   output bit upd);
            purge       = 1'b0;
            cancel      = 1'b0;
            upd         = 1'b0;
            purge_code  = ACT_CREATE_RT;
            cancel_code = ACT_CREATE_RT;
            case (a)
                ACT_DESTROY_RT: begin
                    cancel = 1'b1; cancel_code = ACT_CREATE_RT;
                end
                ACT_DESTROY_RB: begin
                    purge  = 1'b1; purge_code  = ACT_UPDATE_RB;
                    cancel = 1'b1; cancel_code = ACT_CREATE_RB;
                end
                ACT_DESTROY_BP: begin
                    cancel = 1'b1; cancel_code = ACT_CREATE_BP;
                end
                ACT_DESTROY_DB: begin
                    purge  = 1'b1; purge_code  = ACT_UPDATE_DB;
                    cancel = 1'b1; cancel_code = ACT_CREATE_DB;
                end
                ACT_DESTROY_TB: begin
                    purge  = 1'b1; purge_code  = ACT_UPDATE_TB;
                    cancel = 1'b1; cancel_code = ACT_CREATE_TB;
                end
                ACT_DESTROY_UB: begin
                    purge  = 1'b1; purge_code  = ACT_UPDATE_UB;
                    cancel = 1'b1; cancel_code = ACT_CREATE_UB;
                end
                ACT_UPDATE_RB, ACT_UPDATE_DB, ACT_UPDATE_TB, ACT_UPDATE_UB: begin
                    upd = 1'b1;
                end
                default: begin
                    upd = 1'b0;     // creates go straight to the tail unless the queue is full
                end
            endcase
        endfunction

        // Apply one accepted input transaction and queue the result it owes
        function void note_input(logic op, logic [31:0] h, act_t a);
            queue_result_t r;
            queue_entry_t  e;
            queue_entry_t  kept[$];
            bit            purge, cancel, upd, dropped, found;
            act_t          purge_code, cancel_code;
            int unsigned   n_removed;
            r         = '0;
            dropped   = 1'b0;
            n_removed = 0;
            if (op == OP_POP) begin
                if (held.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    e        = held.pop_front();
                    r.status = ST_POPPED;
                    r.handle = e.handle;
                    r.action = e.action;
                end
            end else begin
                action_rules(a, purge, purge_code, cancel, cancel_code, upd);
                r.status = ST_APPENDED;
                // destroy: drop every queued update of this kind for the handle
                if (purge) begin
                    foreach (held[i]) begin
                        if (held[i].handle == h && held[i].action == purge_code)
                            n_removed++;
                        else
                            kept.insert(kept.size(), held[i]);
                    end
                    held = kept;
                end
                // destroy: the oldest matching create cancels it out
                if (cancel) begin
                    found = 1'b0;
                    for (int i = 0; i < held.size() && !found; i++) begin
                        if (held[i].handle == h && held[i].action == cancel_code) begin
                            held.delete(i);
                            found = 1'b1;
                        end
                    end
                    if (found) begin
                        r.status = ST_CANCELLED;
                        dropped  = 1'b1;
                    end
                end
                if (upd) begin
                    foreach (held[i]) begin
                        if (held[i].handle == h && held[i].action == a) begin
                            r.status = ST_DUP;
                            dropped  = 1'b1;
                        end
                    end
                end
                if (!dropped) begin
                    if (held.size() >= QUEUE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        e.handle = h;
                        e.action = a;
                        held.insert(held.size(), e);
                    end
                end
            end
            r.removed = 6'(n_removed);
            r.count   = 6'(held.size());
            awaited.insert(awaited.size(), r);
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, what, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result transaction with the oldest one owed
        function void check_result(status_t st, logic [47:0] d);
            queue_result_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d data 0x%h",
                         $time, st, d);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("status", 32'(want.status), 32'(st));
            compare_field("out_handle", want.handle, d[31:0]);
            compare_field("out_action", 32'(want.action), 32'(d[35:32]));
            compare_field("updates_removed", 32'(want.removed), 32'(d[41:36]));
            compare_field("queue_count", 32'(want.count), 32'(d[47:42]));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;       // [31:0] res_handle, [35:32] action_code, [39:36] zero
    logic        s_tuser;       // [0] opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;       // [31:0] out_handle, [35:32] out_action,
                                // [41:36] updates_removed, [47:42] queue_count
    logic [2:0]  m_tuser;       // [2:0] status

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    pending_action_queue_coalescer #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (32)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    action_queue_board board;
    bit                burst_mode;      // no idling on either side while set
    bit                rx_hold_request; // receiver does one long hold-off when set
    int unsigned       idle_cycles;
    logic [31:0]       handle_pool[POOL_SIZE];

    // Mostly back-to-back, sometimes a short gap, now and then a long gap
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge. A result is checked
    // before the same edge's input is noted; the output is registered, so a
    // result can never belong to the transaction taken at the same edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                board.check_result(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                board.note_input(s_tuser, s_tdata[31:0], s_tdata[35:32]);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, board.outstanding());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random tready gaps, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int unsigned gap;
        @(posedge aresetn);
        forever begin
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            gap = burst_mode ? 0 : pick_gap();
            if (gap > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------
    // Present one transaction at the falling edge and hold it until taken
    task automatic offer_item(logic op, logic [31:0] h, act_t a);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, a, h};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic sender_gap();
        int unsigned gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic push_action(act_t a, logic [31:0] h);
        offer_item(OP_PUSH, h, a);
        sender_gap();
    endtask

    // The block ignores handle and action on a pop; send noise there
    task automatic pop_entry();
        offer_item(OP_POP, $urandom, act_t'($urandom_range(0, 15)));
        sender_gap();
    endtask

    // Stop offering and wait until every owed result has been taken
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_pool_handle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'h0000_0000;
        else if (r < 20)
            return 32'hFFFF_FFFF;
        else
            return $urandom;
    endfunction

    // Mostly create/update/destroy of one kind on a small handle pool, so
    // that cancels, purges and dups happen; the rest is any code, any handle.
    task automatic random_push();
        int unsigned kind, stage;
        logic [31:0] h;
        act_t        a;
        if ($urandom_range(0, 99) < 70) begin
            kind  = $urandom_range(0, 5);
            stage = $urandom_range(0, 99);
            h     = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (stage < 30)
                a = CREATE_OF[kind];
            else if (stage < 70)
                a = UPDATE_OF[kind];
            else
                a = DESTROY_OF[kind];
        end else begin
            a = act_t'($urandom_range(0, 15));
            h = ($urandom_range(0, 1) == 0) ? handle_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : $urandom;
        end
        push_action(a, h);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned pop_pct;
        board           = new();
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = OP_PUSH;
        m_tready        = 1'b0;
        burst_mode      = 1'b0;
        rx_hold_request = 1'b0;
        idle_cycles     = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: every action code, handle extremes, cancels, purges, dups
        pop_entry();                                    // pop on an empty queue
        push_action(ACT_CREATE_RT,  32'h0000_0000);
        push_action(ACT_DESTROY_RT, 32'h0000_0000);     // cancels the create
        push_action(ACT_DESTROY_RT, 32'hFFFF_FFFF);     // nothing to cancel, appended
        push_action(ACT_CREATE_RB,  32'hA5A5_A5A5);
        push_action(ACT_UPDATE_RB,  32'hA5A5_A5A5);
        push_action(ACT_UPDATE_RB,  32'hA5A5_A5A5);     // duplicate update
        push_action(ACT_UPDATE_RB,  32'h5A5A_5A5A);     // other handle, appended
        push_action(ACT_DESTROY_RB, 32'hA5A5_A5A5);     // purge one update, cancel
        push_action(ACT_CREATE_TB,  32'h0000_0001);
        push_action(ACT_UPDATE_TB,  32'h0000_0001);
        push_action(ACT_CREATE_TB,  32'h0000_0001);     // second create stays
        push_action(ACT_DESTROY_TB, 32'h0000_0001);     // cancels only the first
        push_action(ACT_CREATE_BP,  32'h0000_0002);
        push_action(ACT_DESTROY_BP, 32'h0000_0002);
        push_action(ACT_DESTROY_BP, 32'h8000_0000);
        push_action(ACT_CREATE_DB,  32'h0000_0007);
        push_action(ACT_UPDATE_DB,  32'h0000_0007);
        push_action(ACT_DESTROY_DB, 32'h0000_0008);     // no match at all
        push_action(ACT_CREATE_UB,  32'h7FFF_FFFF);
        push_action(ACT_UPDATE_UB,  32'h7FFF_FFFF);
        push_action(ACT_UPDATE_UB,  32'h7FFF_FFFF);
        push_action(ACT_DESTROY_UB, 32'h7FFF_FFFF);
        pop_entry();
        pop_entry();
        wait_drained();

        // Random: fill / mixed / drain phases, so the queue hits full and empty
        for (int p = 0; p < PHASES; p++) begin
            foreach (handle_pool[i]) handle_pool[i] = pick_pool_handle();
            burst_mode = ($urandom_range(0, 3) == 0);
            case (p % 3)
                0:       pop_pct = 3;
                1:       pop_pct = 35;
                default: pop_pct = 65;
            endcase
            // receiver stalls long while the sender keeps offering
            if (p == 4)
                rx_hold_request = 1'b1;
            // sender pauses until the block has nothing left to report
            if (p == 7 || p == 11)
                wait_drained();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) < pop_pct)
                    pop_entry();
                else
                    random_push();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
rtl/pacq_pkg.sv
rtl/pacq_ram.sv
rtl/pacq_match.sv
rtl/pending_action_queue_coalescer.sv
sim/pending_action_queue_coalescer_tb.sv
